// File: hdl/hdlc_frame_receiver_macros.svh
// Assertion helpers shared by the symbol sequencer and the result queue.
// Define ASSERT_OFF to compile the checks out.
`ifndef HDLC_FRAME_RECEIVER_MACROS_SVH
`define HDLC_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define HFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define HFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define HFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/hfr_pkg.sv
`default_nettype none

package hfr_pkg;

    // Defaults and widths
    localparam int LENGTH_BITS_DEF = 10;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 10;
    localparam int WIN_W           = 16;
    localparam int WCNT_W          = 4;
    localparam int CMP_W           = 17;
    localparam int RES_MAX         = 3;
    localparam int RES_FIFO_DEPTH  = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PATTERN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 1'b1;

    // Reset values
    localparam logic [7:0]       FLAG_RESET      = 8'h7E;
    localparam logic [9:0]       MAX_FRAME_RESET = 10'd512;
    localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'hFFFF;
    localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY        = 16'h8408;

    typedef enum logic [1:0] {
        SYM_ZERO,
        SYM_ONE,
        SYM_FLAG
    } sym_t;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_SKIP,
        MODE_DATA
    } rx_mode_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_SCAN
    } seq_state_t;

    typedef enum logic [2:0] {
        ST_GOOD,
        ST_CRC_BAD,
        ST_FLAG_MID,
        ST_SIX_ONES,
        ST_TOO_LONG
    } frame_status_t;

    // One decided symbol, sequencer to deframer
    typedef struct packed {
        logic valid;
        sym_t sym;
    } sym_step_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic [2:0] frame_status;
    } result_t;

    // Up to two results written per symbol step
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// File: hdl/hdlc_frame_receiver.sv
// An item is taken while the sequencer is idle, then decided one symbol per
// cycle while the queue has room (a flag consumes eight bits in a single step);
// results reach m_valid in the cycle after the symbol that produces them.
// A new item is taken only once fewer than eight window bits remain undecided;
// a full result queue stalls decoding until m_ready drains it.
// Reset (aresetn, synchronous, active low): window all ones, flag hunt, queue empty.
`default_nettype none

module hdlc_frame_receiver #(
    parameter int LENGTH_BITS = hfr_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_demod_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_data_byte,
    output logic                                m_frame_end,
    output logic [2:0]                          m_frame_status,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hfr_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [7:0]          flag_pattern_reg;
    logic [9:0]          max_frame_bytes_reg;
    logic                room;
    logic                item_start;
    hfr_pkg::sym_step_t  sym_step;
    hfr_pkg::push_t      push;
    hfr_pkg::result_t    m_result;

    assign cfg_ready  = 1'b1;
    assign item_start = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_pattern_reg    <= hfr_pkg::FLAG_RESET;
            max_frame_bytes_reg <= hfr_pkg::MAX_FRAME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hfr_pkg::CFG_FLAG_PATTERN:    flag_pattern_reg    <= cfg_data[7:0];
                hfr_pkg::CFG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    hfr_sym_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .demod_byte   (s_demod_byte),
        .flag_pattern (flag_pattern_reg),
        .step_en      (room),
        .sym_out      (sym_step)
    );

    hfr_deframer #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_deframer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_start      (item_start),
        .sym_in          (sym_step),
        .max_frame_bytes (max_frame_bytes_reg),
        .push            (push)
    );

    hfr_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Result fields
    assign m_data_byte    = m_result.data_byte;
    assign m_frame_end    = m_result.frame_end;
    assign m_frame_status = m_result.frame_status;

endmodule

`default_nettype wire

// File: hdl/hfr_sym_seq.sv
`default_nettype none

`include "hdlc_frame_receiver_macros.svh"

// Bit window and symbol sequencer: one symbol decided per cycle while step_en is high
module hfr_sym_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        demod_byte,
    input  wire logic [7:0]        flag_pattern,
    input  wire logic              step_en,
    output hfr_pkg::sym_step_t     sym_out
);

    hfr_pkg::seq_state_t              state_reg, state_next;
    logic [hfr_pkg::WIN_W-1:0]        window_reg, window_next;
    logic [hfr_pkg::WCNT_W-1:0]       count_reg, count_next;
    logic [hfr_pkg::WCNT_W-1:0]       count_after;
    logic [hfr_pkg::WIN_W-1:0]        window_after;
    logic                             accept;
    logic                             do_step;
    logic                             is_flag;
    hfr_pkg::sym_t                    sym;

    assign accept = s_valid && s_ready;

    // Symbol decision on the low window byte
    always_comb begin
        is_flag = (window_reg[7:0] == flag_pattern);
        if (is_flag) begin
            sym          = hfr_pkg::SYM_FLAG;
            window_after = window_reg >> 8;
            count_after  = count_reg - hfr_pkg::WCNT_W'(8);
        end else begin
            sym          = window_reg[0] ? hfr_pkg::SYM_ONE : hfr_pkg::SYM_ZERO;
            window_after = window_reg >> 1;
            count_after  = count_reg - hfr_pkg::WCNT_W'(1);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hfr_pkg::SEQ_IDLE: begin
                if (accept) state_next = hfr_pkg::SEQ_SCAN;
            end
            hfr_pkg::SEQ_SCAN: begin
                if (step_en && (count_after < hfr_pkg::WCNT_W'(8))) begin
                    state_next = hfr_pkg::SEQ_IDLE;
                end
            end
            default: state_next = hfr_pkg::SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready       = (state_reg == hfr_pkg::SEQ_IDLE);
        do_step       = (state_reg == hfr_pkg::SEQ_SCAN) && step_en;
        sym_out.valid = do_step;
        sym_out.sym   = sym;
    end

    // Window load and shift
    always_comb begin
        window_next = window_reg;
        count_next  = count_reg;
        if (accept) begin
            window_next = window_reg | (hfr_pkg::WIN_W'(demod_byte) << count_reg[2:0]);
            count_next  = count_reg + hfr_pkg::WCNT_W'(8);
        end else if (do_step) begin
            window_next = window_after;
            count_next  = count_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= hfr_pkg::SEQ_IDLE;
            window_reg <= hfr_pkg::WINDOW_RESET;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    `HFR_ASSERT_NXT(a_accept_scans, aclk, aresetn, accept, state_reg == hfr_pkg::SEQ_SCAN)
    `HFR_ASSERT_IMP(a_scan_full, aclk, aresetn, state_reg == hfr_pkg::SEQ_SCAN, count_reg >= hfr_pkg::WCNT_W'(8))
    `HFR_ASSERT_IMP(a_idle_short, aclk, aresetn, state_reg == hfr_pkg::SEQ_IDLE, count_reg < hfr_pkg::WCNT_W'(8))

endmodule

`default_nettype wire

// File: hdl/hfr_deframer.sv
`default_nettype none

// Frame state machine: stuffing, octet assembly, CRC and aborts per symbol
module hfr_deframer #(
    parameter int LENGTH_BITS = hfr_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_start,
    input  wire hfr_pkg::sym_step_t    sym_in,
    input  wire logic [9:0]            max_frame_bytes,
    output hfr_pkg::push_t             push
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    hfr_pkg::rx_mode_t        mode_reg, mode_next;
    logic                     pend_reg, pend_next;
    logic [2:0]               ones_reg, ones_next;
    logic [7:0]               shift_reg, shift_next;
    logic [2:0]               idx_reg, idx_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [15:0]              crc_reg, crc_next;
    logic [15:0]              fcs_reg, fcs_next;
    logic [1:0]               res_cnt_reg, res_cnt_next;

    // Reflected CRC-16-CCITT over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ hfr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic hfr_pkg::result_t mk_end(input hfr_pkg::frame_status_t st);
        hfr_pkg::result_t r;
        r.data_byte    = 8'h00;
        r.frame_end    = 1'b1;
        r.frame_status = st;
        return r;
    endfunction

    // Symbol step
    always_comb begin
        logic              run_data;
        logic              done;
        logic              is_flag;
        logic              is_zero;
        logic              b_pend;
        logic [2:0]        b_ones;
        logic [7:0]        b_shift;
        logic [2:0]        b_idx;
        logic [LENGTH_BITS-1:0] b_len;
        logic [15:0]       b_crc;
        logic [15:0]       b_fcs;
        logic [15:0]       rx;
        logic [1:0]        raw_n;
        logic [1:0]        avail;
        hfr_pkg::result_t  e0;
        hfr_pkg::result_t  e1;
        hfr_pkg::result_t  abort_res;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        ones_next  = ones_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        fcs_next   = fcs_reg;
        run_data   = 1'b0;
        done       = 1'b0;
        raw_n      = 2'd0;
        e0         = '0;
        e1         = '0;
        abort_res  = '0;
        rx         = '0;
        is_flag    = (sym_in.sym == hfr_pkg::SYM_FLAG);
        is_zero    = (sym_in.sym == hfr_pkg::SYM_ZERO);

        // Leaving flag skip starts a fresh frame
        if (mode_reg == hfr_pkg::MODE_SKIP) begin
            b_pend  = 1'b0;
            b_ones  = 3'd0;
            b_shift = 8'h00;
            b_idx   = 3'd0;
            b_len   = '0;
            b_crc   = hfr_pkg::CRC_INIT;
            b_fcs   = 16'h0000;
        end else begin
            b_pend  = pend_reg;
            b_ones  = ones_reg;
            b_shift = shift_reg;
            b_idx   = idx_reg;
            b_len   = len_reg;
            b_crc   = crc_reg;
            b_fcs   = fcs_reg;
        end

        if (sym_in.valid) begin
            unique case (mode_reg)
                hfr_pkg::MODE_HUNT: begin
                    if (is_flag) mode_next = hfr_pkg::MODE_SKIP;
                end
                hfr_pkg::MODE_SKIP: begin
                    if (!is_flag) begin
                        mode_next = hfr_pkg::MODE_DATA;
                        run_data  = 1'b1;
                    end
                end
                hfr_pkg::MODE_DATA: run_data = 1'b1;
                default: mode_next = hfr_pkg::MODE_HUNT;
            endcase
        end

        if (run_data) begin
            pend_next  = b_pend;
            ones_next  = b_ones;
            shift_next = b_shift;
            idx_next   = b_idx;
            len_next   = b_len;
            crc_next   = b_crc;
            fcs_next   = b_fcs;
            if (b_ones == 3'd5) begin
                // stuffed zero expected after five ones
                if (!is_zero) begin
                    e0        = mk_end(hfr_pkg::ST_SIX_ONES);
                    raw_n     = 2'd1;
                    mode_next = hfr_pkg::MODE_HUNT;
                end else begin
                    ones_next = 3'd0;
                end
            end else begin
                // completed octet goes out once the next symbol is seen
                if (b_pend) begin
                    pend_next       = 1'b0;
                    e0.data_byte    = b_shift;
                    e0.frame_end    = 1'b0;
                    e0.frame_status = hfr_pkg::ST_GOOD;
                    raw_n           = 2'd1;
                    if (b_len >= LENGTH_BITS'(2)) crc_next = crc_byte(b_crc, b_fcs[15:8]);
                    fcs_next = {b_fcs[7:0], b_shift};
                    if (b_len != LEN_MAX) len_next = b_len + LENGTH_BITS'(1);
                    if (is_flag) begin
                        // closing flag: check FCS
                        rx = {~fcs_next[7:0], ~fcs_next[15:8]};
                        if ((len_next >= LENGTH_BITS'(3)) && (rx == crc_next)) begin
                            e1 = mk_end(hfr_pkg::ST_GOOD);
                        end else begin
                            e1 = mk_end(hfr_pkg::ST_CRC_BAD);
                        end
                        raw_n     = 2'd2;
                        mode_next = hfr_pkg::MODE_SKIP;
                        done      = 1'b1;
                    end
                end
                if (!done) begin
                    if ((b_idx == 3'd0) &&
                        (hfr_pkg::CMP_W'(len_next) > hfr_pkg::CMP_W'(max_frame_bytes))) begin
                        abort_res = mk_end(hfr_pkg::ST_TOO_LONG);
                        mode_next = hfr_pkg::MODE_HUNT;
                        done      = 1'b1;
                    end else begin
                        shift_next = {!is_zero, b_shift[7:1]};
                        ones_next  = is_zero ? 3'd0 : (b_ones + 3'd1);
                        if (is_flag) begin
                            abort_res = mk_end(hfr_pkg::ST_FLAG_MID);
                            mode_next = hfr_pkg::MODE_SKIP;
                            done      = 1'b1;
                        end else begin
                            idx_next = b_idx + 3'd1;
                            if (idx_next == 3'd0) pend_next = 1'b1;
                        end
                    end
                    // abort result follows any octet already emitted
                    if (done) begin
                        if (raw_n == 2'd0) e0 = abort_res;
                        else e1 = abort_res;
                        raw_n = raw_n + 2'd1;
                    end
                end
            end
        end

        // Per-item result cap
        avail       = 2'(hfr_pkg::RES_MAX) - res_cnt_reg;
        push.count  = (raw_n > avail) ? avail : raw_n;
        push.first  = e0;
        push.second = e1;
        res_cnt_next = item_start ? 2'd0 : (res_cnt_reg + push.count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= hfr_pkg::MODE_HUNT;
            pend_reg    <= 1'b0;
            ones_reg    <= 3'd0;
            shift_reg   <= 8'h00;
            idx_reg     <= 3'd0;
            len_reg     <= '0;
            crc_reg     <= hfr_pkg::CRC_INIT;
            fcs_reg     <= 16'h0000;
            res_cnt_reg <= 2'd0;
        end else begin
            mode_reg    <= mode_next;
            pend_reg    <= pend_next;
            ones_reg    <= ones_next;
            shift_reg   <= shift_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            fcs_reg     <= fcs_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hfr_result_fifo.sv
`default_nettype none

`include "hdlc_frame_receiver_macros.svh"

// Small result queue: up to two writes and one read per cycle
module hfr_result_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hfr_pkg::push_t      push,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hfr_pkg::result_t         m_result
);

    localparam int DEPTH = hfr_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hfr_pkg::result_t     mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;

    // Status and read side
    always_comb begin
        m_valid  = (count_reg != '0);
        room     = (count_reg <= CNT_W'(DEPTH - 2));
        m_result = mem[rd_ptr_reg];
        pop      = m_valid && m_ready;
    end

    // Pointer and fill updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Entry writes
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2) mem[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= push.second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `HFR_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `HFR_ASSERT_IMP(a_push_room, aclk, aresetn, push.count != 2'd0, count_reg <= CNT_W'(DEPTH - 2))
    `HFR_ASSERT_IMP(a_push_count, aclk, aresetn, 1'b1, push.count != 2'd3)

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        FAULT_NONE,
        FAULT_SIX_ONES,
        FAULT_FLAG_MID
    } frame_fault_t;

    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_LIMIT   = 4000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_demod_byte = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [7:0]                     m_data_byte;
    logic                           m_frame_end;
    logic [2:0]                     m_frame_status;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [hfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int          error_count = 0;
    int unsigned bytes_sent = 0;
    bit          idling_on = 1'b1;
    bit          result_taken = 1'b0;
    int unsigned sink_stall = 0;

    // Line bits waiting to be packed into items, earliest first
    bit          line_bits[$];
    int unsigned stuff_ones = 0;

    // Receiver model state and its copy of the registers
    logic [7:0]                          flag_cfg;
    logic [hfr_pkg::CFG_DATA_W-1:0]      max_len_cfg;
    logic [15:0]                         rx_window;
    int unsigned                         rx_window_bits;
    hfr_pkg::rx_mode_t                   rx_mode;
    logic                                octet_ready;
    logic [2:0]                          ones_seen;
    logic [7:0]                          octet_reg;
    logic [2:0]                          octet_bits;
    logic [hfr_pkg::LENGTH_BITS_DEF-1:0] octet_count;
    logic [15:0]                         crc_acc;
    logic [15:0]                         fcs_tail;
    int unsigned                         step_results;
    hfr_pkg::result_t                    expected_rx_items[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hdlc_frame_receiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_demod_byte   (s_demod_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_status (m_frame_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    function automatic int unsigned draw_gap();
        return idling_on ? $urandom_range(0, 16) : 0;
    endfunction

    // Reflected CRC-16-CCITT, one byte
    function automatic logic [15:0] crc16_ccitt_byte(logic [15:0] crc, logic [7:0] d);
        crc = crc ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ hfr_pkg::CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // ---------------------------------------------------------------
    // Receiver model
    // ---------------------------------------------------------------
    function automatic void reset_model();
        flag_cfg       = hfr_pkg::FLAG_RESET;
        max_len_cfg    = hfr_pkg::MAX_FRAME_RESET;
        rx_window      = hfr_pkg::WINDOW_RESET;
        rx_window_bits = 0;
        rx_mode        = hfr_pkg::MODE_HUNT;
        start_frame();
    endfunction

    function automatic void start_frame();
        octet_count = '0;
        octet_reg   = '0;
        octet_bits  = '0;
        ones_seen   = '0;
        octet_ready = 1'b0;
        crc_acc     = hfr_pkg::CRC_INIT;
        fcs_tail    = '0;
    endfunction

    // Only the first RES_MAX results of one item are kept
    function automatic void queue_result(logic [7:0] d, logic e,
                                         hfr_pkg::frame_status_t st);
        hfr_pkg::result_t r;
        if (step_results >= hfr_pkg::RES_MAX) return;
        r.data_byte    = d;
        r.frame_end    = e;
        r.frame_status = st;
        expected_rx_items.push_back(r);
        step_results++;
    endfunction

    function automatic void close_frame(hfr_pkg::frame_status_t st,
                                        hfr_pkg::rx_mode_t next_mode);
        queue_result(8'h00, 1'b1, st);
        rx_mode = next_mode;
    endfunction

    function automatic void take_data_symbol(hfr_pkg::sym_t s);
        hfr_pkg::frame_status_t st;
        // stuffed zero after five ones, or an abort on the sixth
        if (ones_seen == 3'd5) begin
            if (s != hfr_pkg::SYM_ZERO) begin
                close_frame(hfr_pkg::ST_SIX_ONES, hfr_pkg::MODE_HUNT);
                return;
            end
            ones_seen = '0;
            return;
        end
        // a complete octet goes out once the next symbol passed the check
        if (octet_ready) begin
            octet_ready = 1'b0;
            queue_result(octet_reg, 1'b0, hfr_pkg::ST_GOOD);
            if (octet_count >= 2) crc_acc = crc16_ccitt_byte(crc_acc, fcs_tail[15:8]);
            fcs_tail = {fcs_tail[7:0], octet_reg};
            if (octet_count != '1) octet_count = octet_count + 1'b1;
            if (s == hfr_pkg::SYM_FLAG) begin
                st = hfr_pkg::ST_CRC_BAD;
                if (octet_count >= 3 && {~fcs_tail[7:0], ~fcs_tail[15:8]} == crc_acc)
                    st = hfr_pkg::ST_GOOD;
                close_frame(st, hfr_pkg::MODE_SKIP);
                return;
            end
        end
        if (octet_bits == 3'd0 && octet_count > max_len_cfg) begin
            close_frame(hfr_pkg::ST_TOO_LONG, hfr_pkg::MODE_HUNT);
            return;
        end
        octet_reg = {s != hfr_pkg::SYM_ZERO, octet_reg[7:1]};
        if (s != hfr_pkg::SYM_ZERO) ones_seen = ones_seen + 1'b1;
        else ones_seen = '0;
        if (s == hfr_pkg::SYM_FLAG) begin
            close_frame(hfr_pkg::ST_FLAG_MID, hfr_pkg::MODE_SKIP);
            return;
        end
        octet_bits = octet_bits + 1'b1;
        if (octet_bits == 3'd0) octet_ready = 1'b1;
    endfunction

    function automatic void take_symbol(hfr_pkg::sym_t s);
        case (rx_mode)
            hfr_pkg::MODE_HUNT: begin
                if (s == hfr_pkg::SYM_FLAG) rx_mode = hfr_pkg::MODE_SKIP;
            end
            hfr_pkg::MODE_SKIP: begin
                if (s != hfr_pkg::SYM_FLAG) begin
                    start_frame();
                    rx_mode = hfr_pkg::MODE_DATA;
                    take_data_symbol(s);
                end
            end
            hfr_pkg::MODE_DATA: begin
                take_data_symbol(s);
            end
            default: begin
                rx_mode = hfr_pkg::MODE_HUNT;
            end
        endcase
    endfunction

    // Append one item to the window and decide symbols while 8+ bits wait
    function automatic void deframe_byte(logic [7:0] b);
        hfr_pkg::sym_t s;
        step_results   = 0;
        rx_window      = rx_window | (16'(b) << rx_window_bits);
        rx_window_bits = rx_window_bits + 8;
        while (rx_window_bits >= 8) begin
            if (rx_window[7:0] == flag_cfg) begin
                s              = hfr_pkg::SYM_FLAG;
                rx_window      = rx_window >> 8;
                rx_window_bits = rx_window_bits - 8;
            end else begin
                s              = rx_window[0] ? hfr_pkg::SYM_ONE : hfr_pkg::SYM_ZERO;
                rx_window      = rx_window >> 1;
                rx_window_bits = rx_window_bits - 1;
            end
            take_symbol(s);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result check and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        hfr_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_taken = 1'b1;
            if (expected_rx_items.size() == 0) begin
                $error("unexpected item: data_byte %0h frame_end %0b frame_status %0d",
                       m_data_byte, m_frame_end, m_frame_status);
                error_count++;
            end else begin
                want = expected_rx_items.pop_front();
                if (m_data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, actual %0h", want.data_byte, m_data_byte);
                    error_count++;
                end
                if (m_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, m_frame_end);
                    error_count++;
                end
                if (m_frame_status !== want.frame_status) begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, m_frame_status);
                    error_count++;
                end
            end
        end
    end

    // New stall drawn after each accepted result
    always @(negedge aclk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            sink_stall   = draw_gap();
        end
        if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic send_line_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_demod_byte <= b;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic write_register(input logic [hfr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [hfr_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == hfr_pkg::CFG_FLAG_PATTERN) flag_cfg = val[7:0];
        else max_len_cfg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Line bit builders
    function automatic void push_raw(logic [7:0] v, int n);
        for (int k = 0; k < n; k++) line_bits.push_back(v[k]);
    endfunction

    function automatic void push_flag();
        push_raw(flag_cfg, 8);
    endfunction

    function automatic void push_stuffed(logic [7:0] v);
        for (int k = 0; k < 8; k++) begin
            line_bits.push_back(v[k]);
            if (v[k]) stuff_ones++;
            else stuff_ones = 0;
            if (stuff_ones == 5) begin
                line_bits.push_back(1'b0);
                stuff_ones = 0;
            end
        end
    endfunction

    // Send every whole byte of pending line bits
    task automatic flush_line();
        logic [7:0] b;
        while (line_bits.size() >= 8) begin
            for (int k = 0; k < 8; k++) b[k] = line_bits.pop_front();
            send_line_byte(b);
        end
    endtask

    // Opening flags, stuffed payload and FCS, closing flag
    task automatic send_frame(input int unsigned len, input bit bad_fcs,
                              input frame_fault_t fault);
        logic [15:0] crc;
        logic [7:0]  d;
        int unsigned fault_at;
        crc      = hfr_pkg::CRC_INIT;
        fault_at = $urandom_range(0, len);
        repeat ($urandom_range(1, 3)) push_flag();
        stuff_ones = 0;
        for (int unsigned i = 0; i <= len; i++) begin
            if (i == fault_at && fault == FAULT_SIX_ONES) push_raw(8'hFF, 7);
            if (i == fault_at && fault == FAULT_FLAG_MID) begin
                push_raw(8'($urandom), $urandom_range(1, 7));
                push_flag();
            end
            if (i < len) begin
                d   = 8'($urandom);
                crc = crc16_ccitt_byte(crc, d);
                push_stuffed(d);
            end
        end
        crc = ~crc;
        if (bad_fcs) crc[4'($urandom_range(0, 15))] ^= 1'b1;
        push_stuffed(crc[7:0]);
        push_stuffed(crc[15:8]);
        push_flag();
        flush_line();
    endtask

    // Flush the line with flags, then wait until every result is in
    task automatic wait_idle();
        int n;
        push_flag();
        push_flag();
        flush_line();
        @(negedge aclk);
        s_valid <= 1'b0;
        n = 0;
        while (expected_rx_items.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_rx_items.size() != 0) begin
            $error("%0d expected items never arrived", expected_rx_items.size());
            error_count++;
            expected_rx_items.delete();
        end
    endtask

    task automatic reconfigure(input logic [7:0] flag,
                               input logic [hfr_pkg::CFG_DATA_W-1:0] max_len);
        wait_idle();
        write_register(hfr_pkg::CFG_FLAG_PATTERN, hfr_pkg::CFG_DATA_W'(flag));
        write_register(hfr_pkg::CFG_MAX_FRAME_BYTES, max_len);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Ones left in the reset window read as line bits
    task automatic test_initial_window();
        send_line_byte(8'h00);
        send_line_byte(8'hFF);
        send_frame(1, 1'b0, FAULT_NONE);
    endtask

    // Good frame, short frame, corrupted FCS
    task automatic test_frame_status();
        send_frame(1, 1'b0, FAULT_NONE);
        send_frame(0, 1'b0, FAULT_NONE);
        send_frame(2, 1'b1, FAULT_NONE);
    endtask

    // Six ones, flag inside an octet, length limit
    task automatic test_aborts();
        send_frame(2, 1'b0, FAULT_SIX_ONES);
        send_frame(2, 1'b0, FAULT_FLAG_MID);
        reconfigure(hfr_pkg::FLAG_RESET, hfr_pkg::CFG_DATA_W'(3));
        send_frame(3, 1'b0, FAULT_NONE);
        send_frame(1, 1'b0, FAULT_NONE);
    endtask

    // Delimiter set to all zeros and all ones
    task automatic test_flag_extremes();
        reconfigure(8'h00, hfr_pkg::MAX_FRAME_RESET);
        send_line_byte(8'h00);
        send_frame(1, 1'b0, FAULT_NONE);
        reconfigure(8'hFF, hfr_pkg::MAX_FRAME_RESET);
        send_line_byte(8'hFF);
        send_frame(1, 1'b0, FAULT_NONE);
    endtask

    // Mostly well-formed frames with random content, some broken, some noise
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned phase_end;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  flag;
        logic [hfr_pkg::CFG_DATA_W-1:0] max_len;
        goal = bytes_sent + 380;
        while (bytes_sent < goal) begin
            pick = $urandom_range(0, 9);
            flag = (pick < 6) ? hfr_pkg::FLAG_RESET :
                   (pick == 6) ? 8'h00 :
                   (pick == 7) ? 8'hFF : 8'($urandom);
            pick = $urandom_range(0, 3);
            max_len = (pick == 0) ? hfr_pkg::CFG_DATA_W'(3) :
                      (pick == 1) ? '1 :
                      (pick == 2) ? hfr_pkg::MAX_FRAME_RESET :
                      hfr_pkg::CFG_DATA_W'($urandom_range(3, 40));
            reconfigure(flag, max_len);
            idling_on = ($urandom_range(0, 3) != 0);
            phase_end = bytes_sent + $urandom_range(40, 90);
            while (bytes_sent < phase_end && bytes_sent < goal) begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 45) :
                                                     $urandom_range(0, 12);
                if (pick < 70) begin
                    send_frame(len, $urandom_range(0, 9) == 0, FAULT_NONE);
                end else if (pick < 78) begin
                    send_frame(len, 1'b0, FAULT_SIX_ONES);
                end else if (pick < 86) begin
                    send_frame(len, 1'b0, FAULT_FLAG_MID);
                end else begin
                    repeat ($urandom_range(1, 6)) push_raw(8'($urandom), 8);
                    flush_line();
                end
            end
        end
        idling_on = 1'b1;
    endtask

    // Largest length limit lets an ordinary frame through
    task automatic test_top_limit();
        reconfigure(hfr_pkg::FLAG_RESET, '1);
        send_frame(20, 1'b0, FAULT_NONE);
        reconfigure(hfr_pkg::FLAG_RESET, hfr_pkg::MAX_FRAME_RESET);
        send_frame(2, 1'b0, FAULT_NONE);
    endtask

    initial begin
        reset_model();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_initial_window();
        test_frame_status();
        test_aborts();
        test_flag_extremes();
        test_random_traffic();
        test_top_limit();
        wait_idle();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
